[rtl/fht_pkg.sv]
// Shared types and constants for the floor heating thermostat.
// Used by fht_btn, fht_thermo and floor_heating_thermostat_top; no dependencies.
package fht_pkg;

	// Kind of tick carried by a request
	localparam logic TICK_BUTTON = 1'b0;
	localparam logic TICK_THERMO = 1'b1;

	// Heating modes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_WINDOW = 2'd1;
	localparam logic [1:0] MODE_ALWAYS = 2'd2;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_WINDOW_START   = 3'd0;
	localparam logic [2:0] REG_WINDOW_END     = 3'd1;
	localparam logic [2:0] REG_TEMP_ON_BELOW  = 3'd2;
	localparam logic [2:0] REG_TEMP_OFF_ABOVE = 3'd3;
	localparam logic [2:0] REG_ERROR_LIMIT    = 3'd4;
	localparam logic [2:0] REG_PRESS_MIN      = 3'd5;
	localparam logic [2:0] REG_PRESS_MAX      = 3'd6;

	// Reset values
	localparam logic [9:0]  ERROR_LIMIT_RST = 10'd600;
	localparam logic [15:0] PRESS_MIN_RST   = 16'd30;
	localparam logic [15:0] PRESS_MAX_RST   = 16'd1500;
	localparam logic signed [8:0] HELD_TEMP_RST = 9'sd1;

	// Sensor error codes, tenths of a degree
	localparam logic signed [12:0] ERR_CODE_ZERO = 13'sd0;
	localparam logic signed [12:0] ERR_CODE_A    = 13'sd850;
	localparam logic signed [12:0] ERR_CODE_B    = 13'sd2550;

	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [4:0] LAST_HOUR     = 5'd23;

	typedef struct packed {
		logic [4:0]        window_start;
		logic [4:0]        window_end;
		logic signed [8:0] temp_on_below;
		logic signed [8:0] temp_off_above;
		logic [9:0]        error_limit;
		logic [15:0]       press_min_ticks;
		logic [15:0]       press_max_ticks;
	} cfg_t;

	// Thermostat state as seen after a request
	typedef struct packed {
		logic              heater;
		logic              in_window;
		logic signed [8:0] held_temp;
		logic              reading_bad;
	} thermo_res_t;

endpackage

[rtl/fht_btn.sv]
// Push button press timer and heating mode selector.
// Depends on fht_pkg.
module fht_btn (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick_en,
	input  logic           btn_en,
	input  logic           button_level,
	input  fht_pkg::cfg_t  cfg,
	output logic [1:0]     mode_fix,
	output logic [1:0]     mode_d
);
	import fht_pkg::*;

	logic        last_level_q;
	logic [1:0]  edge_cnt_q;
	logic [15:0] press_ticks_q;
	logic [1:0]  mode_q;

	logic        last_level_n;
	logic [1:0]  edge_cnt_inc;
	logic [1:0]  edge_cnt_n;
	logic [15:0] press_inc;
	logic [15:0] press_n;
	logic        press;
	logic [1:0]  mode_step;

	always_comb begin
		mode_fix     = (mode_q > MODE_ALWAYS) ? MODE_OFF : mode_q;
		last_level_n = button_level;
		edge_cnt_inc = (button_level != last_level_q) ? 2'(edge_cnt_q + 2'd1) : edge_cnt_q;
		press_inc    = press_ticks_q;
		if (edge_cnt_inc == 2'd1 && !last_level_n && press_ticks_q != 16'hFFFF) begin
			press_inc = 16'(press_ticks_q + 16'd1);
		end
		press      = 1'b0;
		press_n    = press_inc;
		edge_cnt_n = edge_cnt_inc;
		// The closing edge of a press ends it: judge its length and restart
		if (edge_cnt_inc > 2'd1) begin
			press = last_level_n && (press_inc > cfg.press_min_ticks) &&
				(press_inc < cfg.press_max_ticks);
			press_n    = '0;
			edge_cnt_n = '0;
		end
		mode_step = (mode_fix == MODE_ALWAYS) ? MODE_OFF : 2'(mode_fix + 2'd1);
		mode_d    = (btn_en && press) ? mode_step : mode_fix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b1;
			edge_cnt_q    <= '0;
			press_ticks_q <= '0;
			mode_q        <= MODE_OFF;
		end else begin
			if (tick_en) begin
				mode_q <= mode_d;
			end
			if (btn_en) begin
				last_level_q  <= last_level_n;
				edge_cnt_q    <= edge_cnt_n;
				press_ticks_q <= press_n;
			end
		end
	end

endmodule

[rtl/fht_thermo.sv]
// Temperature hold with error skipping, hour window and hysteresis heater control.
// Depends on fht_pkg.
module fht_thermo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  thermo_en,
	input  logic signed [12:0]    temp_reading,
	input  logic [4:0]            hour,
	input  logic [1:0]            mode_fix,
	input  fht_pkg::cfg_t         cfg,
	output fht_pkg::thermo_res_t  res_d
);
	import fht_pkg::*;

	localparam logic [12:0] RECIP_10 = 13'd6554; // 65536 / 10, rounded up

	logic signed [8:0] held_q;
	logic [9:0]        bad_ticks_q;
	logic              heater_q;
	logic              window_q;

	logic [12:0]       mag;
	logic [25:0]       prod;
	logic [9:0]        quo;
	logic [9:0]        quo_neg;
	logic signed [8:0] scaled;
	logic              bad;
	logic [9:0]        bad_inc;
	logic              take_raw;
	logic signed [8:0] held_n;
	logic [9:0]        bad_n;
	logic [4:0]        ws;
	logic [4:0]        we;
	logic              win_n;
	logic              heater_n;

	always_comb begin
		// Divide by 10, truncate toward zero, saturate to 9 bits signed
		mag     = temp_reading[12] ? 13'(~temp_reading + 13'sd1) : 13'(temp_reading);
		prod    = mag * RECIP_10;
		quo     = prod[25:16];
		quo_neg = 10'(~quo + 10'd1);
		if (temp_reading[12]) begin
			scaled = (quo > 10'd256) ? -9'sd256 : $signed(quo_neg[8:0]);
		end else begin
			scaled = (quo > 10'd255) ? 9'sd255 : $signed(quo[8:0]);
		end

		bad = (temp_reading == ERR_CODE_ZERO) || (temp_reading == ERR_CODE_A) ||
			(temp_reading == ERR_CODE_B);
		bad_inc  = bad ? 10'(bad_ticks_q + 10'd1) : bad_ticks_q;
		take_raw = (cfg.error_limit <= bad_inc);
		held_n   = (!bad || take_raw) ? scaled : held_q;
		bad_n    = take_raw ? '0 : bad_inc;

		ws = (cfg.window_start > LAST_HOUR) ? 5'd0 : cfg.window_start;
		we = (cfg.window_end > LAST_HOUR) ? 5'd0 : cfg.window_end;
		if (ws < we) begin
			win_n = (ws <= hour) && (hour < we);
		end else begin
			win_n = ((ws <= hour) && (hour < HOURS_PER_DAY)) || (hour < we);
		end

		heater_n = heater_q;
		if (mode_fix == MODE_OFF || (mode_fix == MODE_WINDOW && !win_n)) begin
			heater_n = 1'b0;
		end else begin
			// Turn-on check last so it wins when both thresholds hit
			if (cfg.temp_off_above < held_n) heater_n = 1'b0;
			if (held_n < cfg.temp_on_below) heater_n = 1'b1;
		end

		res_d.heater      = thermo_en ? heater_n : heater_q;
		res_d.in_window   = thermo_en ? win_n : window_q;
		res_d.held_temp   = thermo_en ? held_n : held_q;
		res_d.reading_bad = thermo_en && bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= HELD_TEMP_RST;
			bad_ticks_q <= '0;
			heater_q    <= 1'b0;
			window_q    <= 1'b0;
		end else if (thermo_en) begin
			held_q      <= held_n;
			bad_ticks_q <= bad_n;
			heater_q    <= heater_n;
			window_q    <= win_n;
		end
	end

endmodule

[rtl/floor_heating_thermostat_top.sv]
// Floor heating thermostat: input register, tick logic, result register, APB registers.
// Depends on fht_pkg, fht_btn and fht_thermo.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------------
//   in      | in_valid / in_stall   | mode, button_level, temp_reading, hour
//   out     | out_valid / out_stall | heater, heating_mode, in_window, held_temp,
//           |                       | reading_bad
//   cfg     | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// Each request passes the input register, then the tick logic, then the result register;
// one request per cycle sustained while out is not stalled.
// Reset clears the valid flags, tick state and configuration to their defaults; the payload
// registers are not reset. No clearing pass.
// A stall on out holds the result; in stalls only while a request waits in the input
// register that cannot move into the full, stalled result register.
module floor_heating_thermostat_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic               button_level,
	input  logic signed [12:0] temp_reading,
	input  logic [4:0]         hour,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               heater,
	output logic [1:0]         heating_mode,
	output logic               in_window,
	output logic signed [8:0]  held_temp,
	output logic               reading_bad,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import fht_pkg::*;

	cfg_t cfg_q;

	logic               valid_s1;
	logic               mode_s1;
	logic               level_s1;
	logic signed [12:0] reading_s1;
	logic [4:0]         hour_s1;

	logic               advance;
	logic               btn_en;
	logic               thermo_en;
	logic [1:0]         mode_fix;
	logic [1:0]         mode_d;
	thermo_res_t        res_d;
	logic [2:0]         reg_idx;

	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign btn_en    = advance && (mode_s1 == TICK_BUTTON);
	assign thermo_en = advance && (mode_s1 == TICK_THERMO);

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start    <= '0;
			cfg_q.window_end      <= '0;
			cfg_q.temp_on_below   <= '0;
			cfg_q.temp_off_above  <= '0;
			cfg_q.error_limit     <= ERROR_LIMIT_RST;
			cfg_q.press_min_ticks <= PRESS_MIN_RST;
			cfg_q.press_max_ticks <= PRESS_MAX_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_WINDOW_START:   cfg_q.window_start    <= pwdata[4:0];
				REG_WINDOW_END:     cfg_q.window_end      <= pwdata[4:0];
				REG_TEMP_ON_BELOW:  cfg_q.temp_on_below   <= $signed(pwdata[8:0]);
				REG_TEMP_OFF_ABOVE: cfg_q.temp_off_above  <= $signed(pwdata[8:0]);
				REG_ERROR_LIMIT:    cfg_q.error_limit     <= pwdata[9:0];
				REG_PRESS_MIN:      cfg_q.press_min_ticks <= pwdata[15:0];
				REG_PRESS_MAX:      cfg_q.press_max_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_START:   prdata = 32'(cfg_q.window_start);
			REG_WINDOW_END:     prdata = 32'(cfg_q.window_end);
			REG_TEMP_ON_BELOW:  prdata = 32'($unsigned(cfg_q.temp_on_below));
			REG_TEMP_OFF_ABOVE: prdata = 32'($unsigned(cfg_q.temp_off_above));
			REG_ERROR_LIMIT:    prdata = 32'(cfg_q.error_limit);
			REG_PRESS_MIN:      prdata = 32'(cfg_q.press_min_ticks);
			REG_PRESS_MAX:      prdata = 32'(cfg_q.press_max_ticks);
			default:            prdata = '0;
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1    <= mode;
			level_s1   <= button_level;
			reading_s1 <= temp_reading;
			hour_s1    <= hour;
		end
	end

	fht_btn u_btn (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_en      (advance),
		.btn_en       (btn_en),
		.button_level (level_s1),
		.cfg          (cfg_q),
		.mode_fix     (mode_fix),
		.mode_d       (mode_d)
	);

	fht_thermo u_thermo (
		.clk          (clk),
		.arst_n       (arst_n),
		.thermo_en    (thermo_en),
		.temp_reading (reading_s1),
		.hour         (hour_s1),
		.mode_fix     (mode_fix),
		.cfg          (cfg_q),
		.res_d        (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heater       <= res_d.heater;
			heating_mode <= mode_d;
			in_window    <= res_d.in_window;
			held_temp    <= res_d.held_temp;
			reading_bad  <= res_d.reading_bad;
		end
	end

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heating_mode <= MODE_ALWAYS))
		else $error("heating mode out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_button_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		btn_en |=> (out_valid && !reading_bad))
		else $error("button request flagged a bad reading");

	a_off_no_heat: assert property (@(posedge clk) disable iff (!arst_n)
		(thermo_en && mode_fix == MODE_OFF) |=> !heater)
		else $error("heater on while heating is off");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("request lost between registers");

endmodule

[verif/floor_heating_thermostat_top_test.sv]
// Self-checking bench for floor_heating_thermostat_top: a short scripted run, then
// random ticks under several register settings and stall patterns.
// Depends on fht_pkg and the RTL of floor_heating_thermostat_top.
`timescale 1ns / 100ps

module floor_heating_thermostat_top_test;
	import fht_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		logic              kind;
		logic              level;
		logic signed [12:0] reading;
		logic [4:0]        hr;
	} tick_t;

	typedef struct {
		logic              heater;
		logic [1:0]        heating_mode;
		logic              in_window;
		logic signed [8:0] held_temp;
		logic              reading_bad;
	} status_t;

	typedef struct {
		tick_t   t;
		logic    typed;
		status_t want;
	} stim_row_t;

	localparam status_t NO_WANT = '{default: '0};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic               button_level;
	logic signed [12:0] temp_reading;
	logic [4:0]         hour;
	logic               out_valid;
	logic               out_stall;
	logic               heater;
	logic [1:0]         heating_mode;
	logic               in_window;
	logic signed [8:0]  held_temp;
	logic               reading_bad;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Thermostat state as predicted by the bench
	logic       pin_prev;
	int         pin_edges;
	int         hold_len;
	logic [1:0] sel_mode;
	int         temp_deg;
	int         err_run;
	logic       heat_q;
	logic       win_q;

	// Register copies
	int win_open_hr;
	int win_close_hr;
	int on_thresh;
	int off_thresh;
	int err_limit;
	int hold_min;
	int hold_max;

	status_t pending_status[$];
	int      mismatch_count;
	int      quiet_cycles;
	int      tx_idle_pct;
	int      rx_idle_pct;

	// Scripted requests; rows marked typed carry a hand-written expectation
	stim_row_t script [23] = '{
		// reset state, released button
		'{'{TICK_BUTTON, 1'b1, 13'sd0, 5'd0}, 1'b1, '{1'b0, MODE_OFF, 1'b0, 9'sd1, 1'b0}},
		// the three sensor error codes keep the old temperature
		'{'{TICK_THERMO, 1'b1, 13'sd0, 5'd0}, 1'b1, '{1'b0, MODE_OFF, 1'b1, 9'sd1, 1'b1}},
		'{'{TICK_THERMO, 1'b0, 13'sd850, 5'd23}, 1'b1, '{1'b0, MODE_OFF, 1'b1, 9'sd1, 1'b1}},
		'{'{TICK_THERMO, 1'b1, 13'sd2550, 5'd5}, 1'b1, '{1'b0, MODE_OFF, 1'b1, 9'sd1, 1'b1}},
		// largest reading saturates high; hour past the day is outside
		'{'{TICK_THERMO, 1'b0, 13'sd4095, 5'd31}, 1'b1,
			'{1'b0, MODE_OFF, 1'b0, 9'sd255, 1'b0}},
		// most negative reading saturates low
		'{'{TICK_THERMO, 1'b1, 13'sh1000, 5'd0}, 1'b1,
			'{1'b0, MODE_OFF, 1'b1, 9'sh100, 1'b0}},
		'{'{TICK_THERMO, 1'b0, -13'sd550, 5'd12}, 1'b0, NO_WANT},
		'{'{TICK_THERMO, 1'b0, -13'sd9, 5'd7}, 1'b0, NO_WANT},
		// one-tick press is too short
		'{'{TICK_BUTTON, 1'b0, 13'sd4095, 5'd31}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b1, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		// two-tick press steps to the window mode
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b1, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_THERMO, 1'b0, 13'sd2549, 5'd4}, 1'b0, NO_WANT},
		'{'{TICK_THERMO, 1'b1, -13'sd10, 5'd9}, 1'b0, NO_WANT},
		// three-tick press steps to always on
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b1, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		// and the next one wraps back to off
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b0, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_BUTTON, 1'b1, 13'sd0, 5'd0}, 1'b0, NO_WANT},
		'{'{TICK_THERMO, 1'b0, 13'sd9, 5'd16}, 1'b0, NO_WANT}
	};

	floor_heating_thermostat_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.button_level (button_level),
		.temp_reading (temp_reading),
		.hour         (hour),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heater       (heater),
		.heating_mode (heating_mode),
		.in_window    (in_window),
		.held_temp    (held_temp),
		.reading_bad  (reading_bad),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	function automatic status_t thermostat_next(tick_t t);
		status_t s;
		logic    step;
		logic    bad;
		int      deg;
		int      ws;
		int      we;
		int      hr;
		step = 1'b0;
		bad  = 1'b0;
		if (t.kind == TICK_BUTTON) begin
			if (t.level != pin_prev) begin
				pin_edges = (pin_edges + 1) & 3;
				pin_prev  = t.level;
			end
			// count low samples only while a press is open, between its opening and closing edge
			if (pin_edges == 1 && !pin_prev && hold_len < 65535)
				hold_len++;
			if (pin_edges > 1) begin
				step      = pin_prev && hold_len > hold_min && hold_len < hold_max;
				hold_len  = 0;
				pin_edges = 0;
			end
			if (step)
				sel_mode = (sel_mode == MODE_ALWAYS) ? MODE_OFF : sel_mode + 2'd1;
		end else begin
			bad = (t.reading == ERR_CODE_ZERO) || (t.reading == ERR_CODE_A) ||
				(t.reading == ERR_CODE_B);
			deg = int'(t.reading) / 10;
			if (deg > 255)
				deg = 255;
			if (deg < -256)
				deg = -256;
			if (!bad)
				temp_deg = deg;
			else
				err_run = (err_run + 1) & 1023;
			// too many bad readings counted since the last take: take the raw one anyway
			if (err_limit <= err_run) begin
				temp_deg = deg;
				err_run  = 0;
			end
			ws = (win_open_hr > LAST_HOUR) ? 0 : win_open_hr;
			we = (win_close_hr > LAST_HOUR) ? 0 : win_close_hr;
			hr = t.hr;
			if (ws < we)
				win_q = (ws <= hr) && (hr < we);
			else
				win_q = ((ws <= hr) && (hr < HOURS_PER_DAY)) || (hr < we);
			if (sel_mode == MODE_OFF || (sel_mode == MODE_WINDOW && !win_q)) begin
				heat_q = 1'b0;
			end else begin
				// switch off first so that switching on wins
				if (off_thresh < temp_deg)
					heat_q = 1'b0;
				if (temp_deg < on_thresh)
					heat_q = 1'b1;
			end
		end
		s.heater       = heat_q;
		s.heating_mode = sel_mode;
		s.in_window    = win_q;
		s.held_temp    = 9'(temp_deg);
		s.reading_bad  = bad;
		return s;
	endfunction

	function automatic tick_t rand_tick(logic kind, logic level);
		tick_t t;
		int    roll;
		t.kind  = kind;
		t.level = level;
		t.hr    = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom_range(31));
		roll    = $urandom_range(99);
		if (roll < 15) begin
			case ($urandom_range(2))
				0: t.reading = ERR_CODE_ZERO;
				1: t.reading = ERR_CODE_A;
				default: t.reading = ERR_CODE_B;
			endcase
		end else if (roll < 35) begin
			t.reading = 13'($urandom);
		end else begin
			t.reading = 13'(int'($urandom_range(3100)) - 550);
		end
		return t;
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WINDOW_START:   win_open_hr  = value[4:0];
			REG_WINDOW_END:     win_close_hr = value[4:0];
			REG_TEMP_ON_BELOW:  on_thresh    = $signed(value[8:0]);
			REG_TEMP_OFF_ABOVE: off_thresh   = $signed(value[8:0]);
			REG_ERROR_LIMIT:    err_limit    = value[9:0];
			REG_PRESS_MIN:      hold_min     = value[15:0];
			REG_PRESS_MAX:      hold_max     = value[15:0];
			default: ;
		endcase
	endtask

	task automatic send_row(tick_t t, logic typed, status_t want);
		status_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= t.kind;
		button_level <= t.level;
		temp_reading <= t.reading;
		hour         <= t.hr;
		// hold the request until the block takes it
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		predicted = thermostat_next(t);
		pending_status.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting(int pick);
		int ws;
		int we;
		int on_t;
		int off_t;
		int lim;
		int pmin;
		int pmax;
		case (pick)
			0: begin
				ws = 8; we = 17; on_t = 20; off_t = 22; lim = 3; pmin = 1; pmax = 6;
			end
			1: begin
				// window wraps past midnight, widest thresholds
				ws = 22; we = 6; on_t = -256; off_t = 255; lim = 0; pmin = 0; pmax = 65535;
			end
			2: begin
				// window hours out of range, both thresholds hit at once, no press fits
				ws = 27; we = 30; on_t = 255; off_t = -256; lim = 1023; pmin = 65535;
				pmax = 0;
			end
			3: begin
				ws = 5; we = 5; on_t = 0; off_t = 0; lim = 1; pmin = 2; pmax = 3;
			end
			default: begin
				ws    = $urandom_range(31);
				we    = $urandom_range(31);
				on_t  = int'($urandom_range(310)) - 55;
				off_t = on_t + int'($urandom_range(6)) - 1;
				lim   = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(8);
				pmin  = $urandom_range(4);
				pmax  = pmin + $urandom_range(6);
			end
		endcase
		reg_write(REG_WINDOW_START, 32'(ws));
		reg_write(REG_WINDOW_END, 32'(we));
		reg_write(REG_TEMP_ON_BELOW, {23'd0, 9'(on_t)});
		reg_write(REG_TEMP_OFF_ABOVE, {23'd0, 9'(off_t)});
		reg_write(REG_ERROR_LIMIT, 32'(lim));
		reg_write(REG_PRESS_MIN, 32'(pmin));
		reg_write(REG_PRESS_MAX, 32'(pmax));
	endtask

	// Mostly whole presses with lengths around the limits, thermostat ticks mixed in,
	// plus stray button samples.
	task automatic random_traffic(int count);
		int sent;
		int roll;
		int cap;
		int len;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				cap = (hold_max < 12) ? hold_max + 1 : 12;
				len = $urandom_range(cap, 1);
				repeat (len) begin
					send_row(rand_tick(TICK_BUTTON, 1'b0), 1'b0, NO_WANT);
					sent++;
					if ($urandom_range(9) == 0) begin
						send_row(rand_tick(TICK_THERMO, 1'($urandom)), 1'b0, NO_WANT);
						sent++;
					end
				end
				send_row(rand_tick(TICK_BUTTON, 1'b1), 1'b0, NO_WANT);
				sent++;
				repeat ($urandom_range(2)) begin
					send_row(rand_tick(TICK_BUTTON, 1'b1), 1'b0, NO_WANT);
					sent++;
				end
			end else if (roll < 88) begin
				send_row(rand_tick(TICK_THERMO, 1'($urandom)), 1'b0, NO_WANT);
				sent++;
			end else begin
				send_row(rand_tick(TICK_BUTTON, 1'($urandom)), 1'b0, NO_WANT);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin : result_check
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				$error("result with no request pending");
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				if (heater !== want.heater) begin
					$error("heater: expected %0d, got %0d", want.heater, heater);
					mismatch_count++;
				end
				if (heating_mode !== want.heating_mode) begin
					$error("heating_mode: expected %0d, got %0d", want.heating_mode,
						heating_mode);
					mismatch_count++;
				end
				if (in_window !== want.in_window) begin
					$error("in_window: expected %0d, got %0d", want.in_window, in_window);
					mismatch_count++;
				end
				if (held_temp !== want.held_temp) begin
					$error("held_temp: expected %0d, got %0d", want.held_temp, held_temp);
					mismatch_count++;
				end
				if (reading_bad !== want.reading_bad) begin
					$error("reading_bad: expected %0d, got %0d", want.reading_bad,
						reading_bad);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("floor_heating_thermostat_top verification failed");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		mode           = TICK_BUTTON;
		button_level   = 1'b1;
		temp_reading   = '0;
		hour           = '0;
		out_stall      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		tx_idle_pct    = 0;
		rx_idle_pct    = 0;

		pin_prev     = 1'b1;
		pin_edges    = 0;
		hold_len     = 0;
		sel_mode     = MODE_OFF;
		temp_deg     = HELD_TEMP_RST;
		err_run      = 0;
		heat_q       = 1'b0;
		win_q        = 1'b0;
		win_open_hr  = 0;
		win_close_hr = 0;
		on_thresh    = 0;
		off_thresh   = 0;
		err_limit    = ERROR_LIMIT_RST;
		hold_min     = PRESS_MIN_RST;
		hold_max     = PRESS_MAX_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short press limits so the script can step the mode
		reg_write(REG_PRESS_MIN, 32'd1);
		reg_write(REG_PRESS_MAX, 32'd4);
		foreach (script[i])
			send_row(script[i].t, script[i].typed, script[i].want);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 9;
					rx_idle_pct = 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct = 9;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 5; seg++) begin
				apply_setting(ph * 5 + seg);
				random_traffic(130);
				wait_drained();
			end
		end

		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("floor_heating_thermostat_top verification clean");
		else
			$display("floor_heating_thermostat_top verification failed");
		$finish;
	end

endmodule
